>>> hw/rtl/order_statistic_multiset_assert.svh
// Assertion macros used by the checker file
`ifndef ORDER_STATISTIC_MULTISET_ASSERT_SVH
`define ORDER_STATISTIC_MULTISET_ASSERT_SVH
// Assert an implication on every clock edge outside reset
`define OSM_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");
// Assert a next-cycle implication outside reset
`define OSM_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");
`endif

>>> hw/rtl/osm_pkg.sv
// Package: constants, command and status codes for the multiset block
package osm_pkg;
  localparam int unsigned Capacity = 1024;
  localparam int unsigned KeyBits  = 32;
  localparam int unsigned IdxBits  = $clog2(Capacity);
  localparam int unsigned UsedBits = $clog2(Capacity + 1);

  typedef logic [KeyBits-1:0] key_t;
  typedef logic [31:0]        cnt_t;
  typedef logic [IdxBits-1:0] idx_t;
  typedef logic [UsedBits-1:0] used_t;

  typedef enum logic [1:0] {
    CmdInsert     = 2'd0,
    CmdRankInsert = 2'd1,
    CmdRank       = 2'd2,
    CmdSelect     = 2'd3
  } cmd_e;

  typedef enum logic [1:0] {
    StOk      = 2'd0,
    StRange   = 2'd1,
    StDropped = 2'd2
  } status_e;

  localparam cnt_t CntMax = '1;
endpackage

>>> hw/rtl/osm_ram.sv
// Generic single-port RAM with registered read data
module osm_ram #(
  parameter int unsigned Depth = 1024,
  parameter int unsigned Width = 32
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] addr_i,
  input  logic [Width-1:0]         wdata_i,
  output logic [Width-1:0]         rdata_o
);
  logic [Width-1:0] mem [Depth];

  // write or read one entry per cycle
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[addr_i] <= wdata_i;
    end
    rdata_o <= mem[addr_i];
  end
endmodule

>>> hw/rtl/order_statistic_multiset.sv
// Top level: sorted key/count table with insert, rank and select commands
//
//   channel   | handshake           | fields
//   ----------+---------------------+-------------------------
//   command   | start_i / busy_o    | cmd_i, operand_i
//   result    | done_o (one cycle)  | value_o, status_o
//
// Each command walks the table one entry at a time (SRead, SCheck) through a
// single RAM port pair: a scan of up to used entries, then for a new key a shift
// that moves one entry at a time (SShRd, SShWr). A select out of range skips the walk.
// Rank-insert runs a rank scan and then an insert scan.
// Memories need no clearing: entries at or above the used count are never read.
// The receiver cannot stall; busy_o is low only in the idle state.
module order_statistic_multiset (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  start_i,
  output logic                  busy_o,
  input  logic [1:0]            cmd_i,
  input  logic [31:0]           operand_i,
  output logic                  done_o,
  output logic [31:0]           value_o,
  output logic [1:0]            status_o
);
  import osm_pkg::*;

  typedef enum logic [7:0] {
    SIdle  = 8'b0000_0001,
    SRead  = 8'b0000_0010,
    SCheck = 8'b0000_0100,
    SFound = 8'b0000_1000,
    SShRd  = 8'b0001_0000,
    SShWr  = 8'b0010_0000,
    SPlace = 8'b0100_0000,
    SDone  = 8'b1000_0000
  } state_e;

  typedef enum logic [1:0] {
    ScRank   = 2'd0,
    ScInsert = 2'd1,
    ScSelect = 2'd2
  } scan_e;

  state_e    state_q, state_d;
  scan_e     scan_q, scan_d;
  cmd_e      cmd_q, cmd_d;
  key_t      key_q, key_d;
  logic [31:0] op_q, op_d;
  logic [32:0] acc_q, acc_d;
  used_t     pos_q, pos_d;
  used_t     used_q, used_d;
  cnt_t      total_q, total_d;
  logic [31:0] value_q, value_d;
  status_e   status_q, status_d;
  key_t      shk_q, shk_d;
  cnt_t      shc_q, shc_d;

  logic  we;
  idx_t  addr;
  key_t  kw, kr;
  cnt_t  cw, cr;
  logic [32:0] accsum;

  osm_ram #(.Depth(Capacity), .Width(KeyBits)) u_keys (
    .clk_i(clk_i), .we_i(we), .addr_i(addr), .wdata_i(kw), .rdata_o(kr));
  osm_ram #(.Depth(Capacity), .Width(32)) u_cnts (
    .clk_i(clk_i), .we_i(we), .addr_i(addr), .wdata_i(cw), .rdata_o(cr));

  assign accsum = acc_q + {1'b0, cr};

  // sequence the scan, shift and update steps
  always_comb begin
    state_d = state_q; scan_d = scan_q; cmd_d = cmd_q; key_d = key_q; op_d = op_q;
    acc_d = acc_q; pos_d = pos_q; used_d = used_q; total_d = total_q;
    value_d = value_q; status_d = status_q; shk_d = shk_q; shc_d = shc_q;
    we = 1'b0; addr = pos_q[IdxBits-1:0]; kw = key_q; cw = 32'd1;
    case (state_q)
      SIdle: begin
        if (start_i) begin
          cmd_d = cmd_e'(cmd_i); op_d = operand_i; key_d = operand_i[KeyBits-1:0];
          acc_d = '0; pos_d = '0; value_d = '0; status_d = StOk;
          case (cmd_e'(cmd_i))
            CmdInsert: scan_d = ScInsert;
            CmdSelect: scan_d = ScSelect;
            default:   scan_d = ScRank;
          endcase
          if (cmd_e'(cmd_i) == CmdSelect &&
              (operand_i == '0 || operand_i > total_q)) begin
            status_d = StRange; state_d = SDone;
          end else begin
            state_d = SRead;
          end
        end
      end
      SRead: begin
        if (pos_q >= used_q) begin
          // end of table
          case (scan_q)
            ScRank: begin
              value_d = (acc_q > {1'b0, CntMax}) ? CntMax : acc_q[31:0];
              if (cmd_q == CmdRankInsert) begin
                key_d = key_q + value_d[KeyBits-1:0];
                scan_d = ScInsert; pos_d = '0; state_d = SRead;
              end else begin
                state_d = SDone;
              end
            end
            ScInsert: state_d = SFound;
            default: begin
              status_d = StRange; state_d = SDone;
            end
          endcase
        end else begin
          state_d = SCheck;
        end
      end
      SCheck: begin
        case (scan_q)
          ScRank: begin
            if (kr > key_q) begin
              pos_d = used_q; state_d = SRead;
            end else begin
              acc_d = accsum; pos_d = pos_q + 1'b1; state_d = SRead;
            end
          end
          ScInsert: begin
            if (kr < key_q) begin
              pos_d = pos_q + 1'b1; state_d = SRead;
            end else if (kr == key_q) begin
              // bump existing count
              we = 1'b1; cw = (cr == CntMax) ? cr : cr + 32'd1;
              if (total_q != CntMax) total_d = total_q + 32'd1;
              state_d = SDone;
            end else begin
              state_d = SFound;
            end
          end
          default: begin
            acc_d = accsum;
            if (accsum >= {1'b0, op_q}) begin
              value_d = 32'(kr); state_d = SDone;
            end else begin
              pos_d = pos_q + 1'b1; state_d = SRead;
            end
          end
        endcase
      end
      SFound: begin
        // new key goes at pos_q; shift from the top down
        if (used_q >= used_t'(Capacity)) begin
          status_d = StDropped; state_d = SDone;
        end else begin
          shk_d = key_q; shc_d = 32'd1;
          acc_d = {{(33-UsedBits){1'b0}}, used_q};
          state_d = (used_q == pos_q) ? SPlace : SShRd;
        end
      end
      SShRd: begin
        addr = IdxBits'(acc_q[UsedBits-1:0] - 1'b1);
        state_d = SShWr;
      end
      SShWr: begin
        we = 1'b1; addr = acc_q[IdxBits-1:0]; kw = kr; cw = cr;
        acc_d = acc_q - 33'd1;
        state_d = (used_t'(acc_q[UsedBits-1:0] - 1'b1) == pos_q) ? SPlace : SShRd;
      end
      SPlace: begin
        we = 1'b1; kw = shk_q; cw = shc_q;
        used_d = used_q + 1'b1;
        if (total_q != CntMax) total_d = total_q + 32'd1;
        state_d = SDone;
      end
      SDone: state_d = SIdle;
      default: state_d = SIdle;
    endcase
  end

  // hold control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= SIdle; used_q <= '0; total_q <= '0;
    end else begin
      state_q <= state_d; used_q <= used_d; total_q <= total_d;
    end
  end

  // hold working payload
  always_ff @(posedge clk_i) begin
    scan_q <= scan_d; cmd_q <= cmd_d; key_q <= key_d; op_q <= op_d; acc_q <= acc_d;
    pos_q <= pos_d; value_q <= value_d; status_q <= status_d;
    shk_q <= shk_d; shc_q <= shc_d;
  end

  assign busy_o   = (state_q != SIdle);
  assign done_o   = (state_q == SDone);
  assign value_o  = value_q;
  assign status_o = status_q;
endmodule

>>> hw/rtl/osm_checker.sv
// Port checker for the multiset block, bound to the top level
`include "order_statistic_multiset_assert.svh"
module osm_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        start_i,
  input logic        busy_o,
  input logic        done_o,
  input logic [31:0] value_o,
  input logic [1:0]  status_o
);
  import osm_pkg::*;

  `OSM_ASSERT_NEXT(a_start_busy, clk_i, rst_ni, start_i && !busy_o, busy_o)
  `OSM_ASSERT_IMPL(a_done_busy, clk_i, rst_ni, done_o, busy_o)
  `OSM_ASSERT_NEXT(a_done_idle, clk_i, rst_ni, done_o, !busy_o && !done_o)
  `OSM_ASSERT_IMPL(a_status_code, clk_i, rst_ni, done_o,
    status_o == StOk || status_o == StRange || status_o == StDropped)
  `OSM_ASSERT_IMPL(a_range_zero, clk_i, rst_ni, done_o && status_o == StRange,
    value_o == '0)
endmodule

bind order_statistic_multiset osm_checker u_osm_checker (.*);

>>> verif/tb_order_statistic_multiset.sv
// Testbench for the order-statistic multiset: directed table, random words, predictor check
module tb_order_statistic_multiset;
  import osm_pkg::*;

  localparam int unsigned CapacityTb = 1024;
  localparam int unsigned NumRandom  = 540;
  localparam longint unsigned CycleLimit = 64'd12_000_000;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        start_i = 1'b0;
  logic [1:0]  cmd_i = CmdInsert;
  logic [31:0] operand_i = '0;
  logic        busy_o;
  logic        done_o;
  logic [31:0] value_o;
  logic [1:0]  status_o;

  order_statistic_multiset dut (
    .clk_i, .rst_ni, .start_i, .busy_o, .cmd_i, .operand_i,
    .done_o, .value_o, .status_o
  );

  always #4 clk_i = ~clk_i;

  // Predictor state: sorted distinct keys with their counts
  logic [31:0] mirror_keys[CapacityTb];
  logic [31:0] mirror_counts[CapacityTb];
  int unsigned mirror_used;
  logic [31:0] mirror_total;

  typedef struct packed {
    logic [31:0] value;
    logic [1:0]  status;
  } answer_t;

  answer_t     pending_answers[$];
  int unsigned mismatch_count;
  int unsigned answers_seen;
  int unsigned words_sent;
  longint unsigned cycle_count;

  // Count items with key <= k, saturated
  function automatic logic [31:0] mirror_rank(logic [31:0] k);
    logic [63:0] sum;
    sum = '0;
    for (int unsigned i = 0; i < mirror_used; i++) begin
      if (mirror_keys[i] > k) break;
      sum += mirror_counts[i];
    end
    return (sum > 64'hFFFF_FFFF) ? CntMax : sum[31:0];
  endfunction

  // Insert one copy of k; return drop status when the table is full
  function automatic status_e mirror_put(logic [31:0] k);
    int unsigned pos;
    pos = 0;
    while (pos < mirror_used && mirror_keys[pos] < k) pos++;
    if (pos < mirror_used && mirror_keys[pos] == k) begin
      if (mirror_counts[pos] != CntMax) mirror_counts[pos]++;
    end else begin
      if (mirror_used >= CapacityTb) return StDropped;
      for (int unsigned j = mirror_used; j > pos; j--) begin
        mirror_keys[j]   = mirror_keys[j-1];
        mirror_counts[j] = mirror_counts[j-1];
      end
      mirror_keys[pos]   = k;
      mirror_counts[pos] = 32'd1;
      mirror_used++;
    end
    if (mirror_total != CntMax) mirror_total++;
    return StOk;
  endfunction

  function automatic answer_t mirror_apply(cmd_e cmd, logic [31:0] op);
    answer_t a;
    logic [31:0] r;
    logic [63:0] seen;
    a = '{value: '0, status: StOk};
    case (cmd)
      CmdInsert: a.status = mirror_put(op);
      CmdRankInsert: begin
        r = mirror_rank(op);
        a.value  = r;
        a.status = mirror_put(op + r);
      end
      CmdRank: a.value = mirror_rank(op);
      default: begin
        a.status = StRange;
        if (op != 0 && op <= mirror_total) begin
          seen = '0;
          for (int unsigned i = 0; i < mirror_used; i++) begin
            seen += mirror_counts[i];
            if (seen >= op) begin
              a.value  = mirror_keys[i];
              a.status = StOk;
              break;
            end
          end
        end
      end
    endcase
    return a;
  endfunction

  // Answer for a row without touching the predictor state
  function automatic answer_t mirror_apply_peek(cmd_e cmd, logic [31:0] op);
    logic [31:0] keys_save[CapacityTb];
    logic [31:0] counts_save[CapacityTb];
    int unsigned used_save;
    logic [31:0] total_save;
    answer_t     a;
    keys_save   = mirror_keys;
    counts_save = mirror_counts;
    used_save   = mirror_used;
    total_save  = mirror_total;
    a = mirror_apply(cmd, op);
    mirror_keys   = keys_save;
    mirror_counts = counts_save;
    mirror_used   = used_save;
    mirror_total  = total_save;
    return a;
  endfunction

  // Check each result word against the oldest expectation
  always @(posedge clk_i) begin
    answer_t want;
    if (rst_ni && done_o) begin
      answers_seen++;
      if (pending_answers.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= 10)
          $display("unexpected result word value=%h status=%0d", value_o, status_o);
      end else begin
        want = pending_answers.pop_front();
        if (want.value !== value_o || want.status !== status_o) begin
          mismatch_count++;
          if (mismatch_count <= 10)
            $display("mismatch: expected value=%h status=%0d, got value=%h status=%0d",
                     want.value, want.status, value_o, status_o);
        end
      end
    end
  end

  // Abort on a hung block
  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CycleLimit) begin
      $display("timeout after %0d cycles", cycle_count);
      $display("simulation failed");
      $finish;
    end
  end

  // Directed rows; check_row marks rows whose answer is typed in
  typedef struct {
    cmd_e        cmd;
    logic [31:0] op;
    bit          check_row;
    logic [31:0] value;
    status_e     status;
  } row_t;

  row_t directed_rows[] = '{
    '{CmdSelect,     32'd0,          1, 32'd0, StRange},
    '{CmdSelect,     32'd1,          1, 32'd0, StRange},
    '{CmdRank,       32'hFFFF_FFFF,  1, 32'd0, StOk},
    '{CmdRankInsert, 32'd5,          1, 32'd0, StOk},
    '{CmdInsert,     32'd0,          1, 32'd0, StOk},
    '{CmdInsert,     32'hFFFF_FFFF,  1, 32'd0, StOk},
    '{CmdInsert,     32'hFFFF_FFFF,  1, 32'd0, StOk},
    '{CmdRank,       32'hFFFF_FFFF,  1, 32'd4, StOk},
    '{CmdRank,       32'd0,          1, 32'd1, StOk},
    '{CmdSelect,     32'd1,          1, 32'd0, StOk},
    '{CmdSelect,     32'd4,          1, 32'hFFFF_FFFF, StOk},
    '{CmdSelect,     32'd5,          1, 32'd0, StRange},
    '{CmdSelect,     32'hFFFF_FFFF,  1, 32'd0, StRange},
    '{CmdRankInsert, 32'hFFFF_FFFE,  0, 32'd0, StOk},
    '{CmdRankInsert, 32'h8000_0000,  0, 32'd0, StOk},
    '{CmdRank,       32'h5555_5555,  0, 32'd0, StOk},
    '{CmdRank,       32'hAAAA_AAAA,  0, 32'd0, StOk},
    '{CmdSelect,     32'd3,          0, 32'd0, StOk},
    '{CmdInsert,     32'h0000_0005,  0, 32'd0, StOk}
  };

  // Hold start until the block takes the word; start stays high unless idle_gap drops it for a gap
  task automatic send_word(cmd_e cmd, logic [31:0] op);
    start_i   <= 1'b1;
    cmd_i     <= cmd;
    operand_i <= op;
    do @(posedge clk_i); while (busy_o);
    pending_answers.push_back(mirror_apply(cmd, op));
    words_sent++;
  endtask

  task automatic idle_gap();
    int unsigned n;
    n = ($urandom_range(0, 9) == 0) ? $urandom_range(5, 40) : $urandom_range(0, 2);
    if (n != 0) begin
      start_i <= 1'b0;
      repeat (n) @(posedge clk_i);
    end
  endtask

  function automatic logic [31:0] pick_key(int unsigned mode);
    case (mode)
      0: return $urandom_range(0, 63);
      1: return 32'hFFFF_FFFF - $urandom_range(0, 15);
      2: return (mirror_used != 0) ? mirror_keys[$urandom_range(0, mirror_used - 1)]
                                   : $urandom();
      default: return $urandom();
    endcase
  endfunction

  initial begin
    int unsigned pick;
    cmd_e        cmd;
    logic [31:0] op;
    answer_t     got;
    mirror_used    = 0;
    mirror_total   = '0;
    mismatch_count = 0;
    answers_seen   = 0;
    words_sent     = 0;
    cycle_count    = 0;
    for (int unsigned i = 0; i < CapacityTb; i++) begin
      mirror_keys[i]   = '0;
      mirror_counts[i] = '0;
    end
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Walk the directed table, checking typed answers against the predictor too
    foreach (directed_rows[i]) begin
      if (directed_rows[i].check_row) begin
        got = mirror_apply_peek(directed_rows[i].cmd, directed_rows[i].op);
        if (got.value !== directed_rows[i].value || got.status !== directed_rows[i].status)
          begin
          mismatch_count++;
          $display("directed row %0d disagrees with typed answer", i);
        end
      end
      send_word(directed_rows[i].cmd, directed_rows[i].op);
      idle_gap();
    end

    // Random words: keys that are small, near the top, taken from the table or fully random
    for (int unsigned n = 0; n < NumRandom; n++) begin
      pick = $urandom_range(0, 9);
      cmd  = cmd_e'(pick < 4 ? CmdInsert : pick < 6 ? CmdRankInsert :
                    pick < 8 ? CmdRank : CmdSelect);
      if (cmd == CmdSelect)
        op = ($urandom_range(0, 7) == 0) ? $urandom() : $urandom_range(0, mirror_total + 2);
      else
        op = pick_key($urandom_range(0, 3));
      send_word(cmd, op);
      idle_gap();
    end

    // A last run of words over all commands, with wide operands except for select
    for (int unsigned n = 0; n < 20; n++) begin
      pick = $urandom_range(0, 3);
      send_word(cmd_e'(pick), (pick == 3) ? $urandom_range(0, mirror_total + 2)
                                          : $urandom());
      idle_gap();
    end
    start_i <= 1'b0;

    // Drain remaining results
    while (pending_answers.size() != 0) @(posedge clk_i);
    repeat (3200) @(posedge clk_i);
    $display("sent %0d command words, checked %0d results, table held %0d keys",
             words_sent, answers_seen, mirror_used);
    $display("covered empty table, extremes, rank-insert wrap and select range");
    if (mismatch_count == 0 && pending_answers.size() == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule

>>> sim.f
+incdir+hw/rtl
hw/rtl/osm_pkg.sv
hw/rtl/osm_ram.sv
hw/rtl/order_statistic_multiset.sv
hw/rtl/osm_checker.sv
verif/tb_order_statistic_multiset.sv
